[rtl/core/wmah_pkg.sv]
// ============================================================================
// wmah_pkg
// Shared types, constants and the rounding helper for the weighted moving
// average block.
// ============================================================================
`default_nettype none

package wmah_pkg;

    // Widths fixed by the word format
    localparam int SAMPLE_W    = 16;
    localparam int PROD_W      = 2 * SAMPLE_W;
    localparam int MAX_TAPS    = 8;
    localparam int NUM_TAPS_DEF = 8;
    // Sum of up to MAX_TAPS full-scale products
    localparam int SUM_W       = PROD_W + $clog2(MAX_TAPS);
    localparam int FRAC_W      = 15;
    localparam int Q_W         = SUM_W - FRAC_W;

    // Config register map
    localparam int CFG_IDX_W   = 4;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_WEIGHT_0 = t_cfg_idx'(0);

    localparam logic signed [SAMPLE_W-1:0] WEIGHT_RST = SAMPLE_W'(4096);

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [SUM_W-1:0]    t_sum;

    // Control from the sequencer to the cell row
    typedef struct packed {
        logic    shift;
        t_sample sample;
    } t_chain_ctl;

    // Status from the cell row back to the sequencer
    typedef struct packed {
        t_sample newest;
        t_sum    sum;
    } t_chain_sts;

    // Q1.15 round half up, then clamp to the sample range
    function automatic t_sample round_sat(input t_sum sum);
        t_sum                      biased;
        logic signed [Q_W-1:0]     q;
        logic signed [Q_W-1:0]     q_max;
        logic signed [Q_W-1:0]     q_min;
        t_sample                   res;
        q_max  = Q_W'(32767);
        q_min  = -Q_W'(32768);
        biased = sum + SUM_W'(1 << (FRAC_W - 1));
        q      = Q_W'(biased >>> FRAC_W);
        if (q > q_max) begin
            res = SAMPLE_W'(32767);
        end else if (q < q_min) begin
            res = -SAMPLE_W'(32768);
        end else begin
            res = q[SAMPLE_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/core/weighted_moving_average_hold_top.sv]
// ============================================================================
// weighted_moving_average_hold_top
// Weighted moving average over the last NUM_TAPS samples with hold on a
// "not visible" (zero) sample once the history is full.
// ============================================================================
// Usage:
//   Input channel  : i_in_valid / o_in_stall, word = i_sample_in (signed 16).
//   Output channel : o_out_valid / i_out_stall, word = o_estimate (signed 16)
//                    and o_history_full.
//   Config port    : i_cfg_we / i_cfg_index / i_cfg_data writes weight_0..7
//                    (Q1.15). Indexes 8 and up are ignored. Write only while
//                    idle.
//   Sequence       : warm-up and hold words reach the output register by way
//                    of the result register; filtered words pass shift,
//                    product, NUM_TAPS cells of partial sum and round. One word
//                    is in work at a time; the next is taken at the edge after
//                    the previous one reaches the output register.
//   Reset          : synchronous, active low; weights return to 0.125
//                    (4096), fill count clears, output register empties.
//   Stall          : a stalled result stays in the output register; the next
//                    word is still accepted and computed, and waits for the
//                    output register to free up.
// ============================================================================
`default_nettype none

module weighted_moving_average_hold_top #(
    parameter int NUM_TAPS = wmah_pkg::NUM_TAPS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // sample input
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire wmah_pkg::t_sample      i_sample_in,
    // estimate output
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output wmah_pkg::t_sample           o_estimate,
    output logic                        o_history_full,
    // weight writes
    input  wire logic                   i_cfg_we,
    input  wire wmah_pkg::t_cfg_idx     i_cfg_index,
    input  wire wmah_pkg::t_sample      i_cfg_data
);

    wmah_pkg::t_chain_ctl   ctl;
    wmah_pkg::t_chain_sts   sts;

    // sample_chain[i] is the output of cell i and feeds cell i-1; entry NUM_TAPS is the incoming word.
    // Cell 0 is the oldest tap, cell NUM_TAPS-1 the newest.
    wmah_pkg::t_sample      sample_chain [NUM_TAPS+1];
    // psum_chain[i] feeds cell i; the sum runs oldest to newest.
    wmah_pkg::t_sum         psum_chain   [NUM_TAPS+1];

    assign sample_chain[NUM_TAPS] = ctl.sample;
    assign psum_chain[0]          = '0;

    for (genvar g = 0; g < NUM_TAPS; g++) begin : g_tap
        wmah_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_shift   (ctl.shift),
            .i_sample  (sample_chain[g+1]),
            .o_sample  (sample_chain[g]),
            .i_wt_we   (i_cfg_we &&
                        (i_cfg_index == wmah_pkg::REG_WEIGHT_0 + wmah_pkg::t_cfg_idx'(g))),
            .i_wt_data (i_cfg_data),
            .i_psum    (psum_chain[g]),
            .o_psum    (psum_chain[g+1])
        );
    end

    // newest stored sample for the hold case, and the finished sum
    assign sts.newest = sample_chain[NUM_TAPS-1];
    assign sts.sum    = psum_chain[NUM_TAPS];

    wmah_ctrl #(
        .NUM_TAPS (NUM_TAPS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample_in    (i_sample_in),
        .o_ctl          (ctl),
        .i_sts          (sts),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_estimate     (o_estimate),
        .o_history_full (o_history_full)
    );

endmodule

`default_nettype wire

[rtl/core/wmah_cell.sv]
// ============================================================================
// wmah_cell
// One tap: holds a sample and its weight, registers the product and adds it
// to the partial sum coming from the older neighbor.
// ============================================================================
`default_nettype none

module wmah_cell (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_shift,
    input  wire wmah_pkg::t_sample    i_sample,
    output wmah_pkg::t_sample         o_sample,
    input  wire logic                 i_wt_we,
    input  wire wmah_pkg::t_sample    i_wt_data,
    input  wire wmah_pkg::t_sum       i_psum,
    output wmah_pkg::t_sum            o_psum
);

    wmah_pkg::t_sample                          r_sample;
    wmah_pkg::t_sample                          r_weight;
    logic signed [wmah_pkg::PROD_W-1:0]         r_prod;
    wmah_pkg::t_sum                             r_psum;
    wmah_pkg::t_sum                             n_psum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= wmah_pkg::WEIGHT_RST;
        end else if (i_wt_we) begin
            r_weight <= i_wt_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_sample <= i_sample;
        end
    end

    // sign-extend the product before adding
    assign n_psum = i_psum + {{(wmah_pkg::SUM_W - wmah_pkg::PROD_W){r_prod[wmah_pkg::PROD_W-1]}},
                              r_prod};

    always_ff @(posedge i_clk) begin
        r_prod <= r_sample * r_weight;
        r_psum <= n_psum;
    end

    assign o_sample = r_sample;
    assign o_psum   = r_psum;

endmodule

`default_nettype wire

[rtl/core/wmah_ctrl.sv]
// ============================================================================
// wmah_ctrl
// Sequencer: input handshake, fill count, wait for the sum wavefront,
// output register.
// ============================================================================
`default_nettype none

module wmah_ctrl #(
    parameter int NUM_TAPS = wmah_pkg::NUM_TAPS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire wmah_pkg::t_sample      i_sample_in,
    output wmah_pkg::t_chain_ctl        o_ctl,
    input  wire wmah_pkg::t_chain_sts   i_sts,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output wmah_pkg::t_sample           o_estimate,
    output logic                        o_history_full
);

    localparam int FILL_W = $clog2(NUM_TAPS + 1);
    localparam int CNT_W  = $clog2(NUM_TAPS + 2);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(NUM_TAPS);
    localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(NUM_TAPS + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CALC = 3'b010,
        ST_WAIT = 3'b100
    } t_state;

    t_state                 r_state, n_state;
    logic [FILL_W-1:0]      r_fill, n_fill;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    wmah_pkg::t_sample      r_res, n_res;
    logic                   r_res_full, n_res_full;
    logic                   r_out_valid, n_out_valid;
    wmah_pkg::t_sample      r_out_est, n_out_est;
    logic                   r_out_full, n_out_full;
    logic                   accept;
    logic                   shift;

    assign accept = (r_state == ST_IDLE) && i_in_valid;

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_cnt       = r_cnt;
        n_res       = r_res;
        n_res_full  = r_res_full;
        n_out_valid = r_out_valid;
        n_out_est   = r_out_est;
        n_out_full  = r_out_full;
        shift       = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (r_fill != FILL_FULL) begin
                        // warm-up: append and pass through
                        shift      = 1'b1;
                        n_fill     = r_fill + FILL_W'(1);
                        n_res      = i_sample_in;
                        n_res_full = (n_fill == FILL_FULL);
                        n_state    = ST_WAIT;
                    end else if (i_sample_in == '0) begin
                        // not visible: hold newest sample
                        n_res      = i_sts.newest;
                        n_res_full = 1'b1;
                        n_state    = ST_WAIT;
                    end else begin
                        shift      = 1'b1;
                        n_res_full = 1'b1;
                        n_cnt      = '0;
                        n_state    = ST_CALC;
                    end
                end
            end
            ST_CALC: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    n_res   = wmah_pkg::round_sat(i_sts.sum);
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_est   = r_res;
                    n_out_full  = r_res_full;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt      <= n_cnt;
        r_res      <= n_res;
        r_res_full <= n_res_full;
        r_out_est  <= n_out_est;
        r_out_full <= n_out_full;
    end

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_ctl.shift    = shift;
    assign o_ctl.sample   = i_sample_in;
    assign o_out_valid    = r_out_valid;
    assign o_estimate     = r_out_est;
    assign o_history_full = r_out_full;

    // ------------------------------------------------------------------------
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_FULL)
        else $error("fill count beyond tap count");

    a_fill_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != $past(r_fill)) |-> $past(accept))
        else $error("fill count moved without an accepted word");

    a_calc_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CALC) |-> (r_fill == FILL_FULL))
        else $error("filter sum started before history full");

    a_shift_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        shift |-> accept)
        else $error("history shifted without an accepted word");

endmodule

`default_nettype wire

[tb/weighted_moving_average_hold_top_tb.sv]
// ============================================================================
// weighted_moving_average_hold_top_tb
// Self-checking bench for the weighted moving average block. It covers the
// warm-up fill, the hold on zero once the history is full, and the Q1.15
// filter with rounding and saturation. A directed table runs first, then
// random phases under several weight sets. Every estimate word is checked
// against a typed result or an in-bench model of the history and the weights.
// ============================================================================
`default_nettype none

module weighted_moving_average_hold_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int       TAPS             = wmah_pkg::NUM_TAPS_DEF;
    localparam int       N_WEIGHTS        = 8;
    // writes at or above this index must be dropped by the block
    localparam wmah_pkg::t_cfg_idx REG_FIRST_UNUSED =
        wmah_pkg::REG_WEIGHT_0 + wmah_pkg::t_cfg_idx'(N_WEIGHTS);
    localparam wmah_pkg::t_cfg_idx REG_LAST_UNUSED  = '1;
    localparam int       LONG_HOLD        = 300;      // output back-pressure
    localparam int       SETTLE_CYCLES    = TAPS + 8; // > filtered latency
    localparam int       RAND_PER_PHASE   = 120;
    localparam int       N_PHASES         = 7;
    localparam int       DUE_DEPTH        = 64;

    typedef struct packed {
        wmah_pkg::t_sample estimate;
        logic              history_full;
    } t_estimate_word;

    // directed row: sample, whether the result is typed in, typed result
    typedef struct packed {
        wmah_pkg::t_sample smp;
        logic              typed;
        wmah_pkg::t_sample est;
        logic              full;
    } t_dir_row;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    wmah_pkg::t_sample  sample_in = '0;
    logic               out_stall = 1'b0;
    logic               cfg_we    = 1'b0;
    wmah_pkg::t_cfg_idx cfg_index = wmah_pkg::REG_WEIGHT_0;
    wmah_pkg::t_sample  cfg_data  = '0;

    logic               in_stall;
    logic               out_valid;
    wmah_pkg::t_sample  estimate;
    logic               history_full;

    // estimates still owed by the block, ring of words, oldest at due_rd
    t_estimate_word estimates_due [DUE_DEPTH];
    int             due_wr        = 0;
    int             due_rd        = 0;
    int             err_cnt       = 0;
    bit             idle_on       = 1'b1;
    bit             hold_off_req  = 1'b0;
    int             stall_left    = 0;

    // bench copy of the block state
    wmah_pkg::t_sample hist [TAPS];
    int                fill;
    wmah_pkg::t_sample wt [N_WEIGHTS];

    // Directed part. Warm-up and hold rows have results readable by eye;
    // filtered rows go through the model (reset weights are 1/8 each).
    t_dir_row dir_tbl [16] = '{
        '{-16'sd32768, 1'b1, -16'sd32768, 1'b0},  // most negative, warm-up
        '{ 16'sd32767, 1'b1,  16'sd32767, 1'b0},  // most positive
        '{ 16'sd0,     1'b1,  16'sd0,     1'b0},  // zero while filling is stored
        '{ 16'sd1,     1'b1,  16'sd1,     1'b0},
        '{-16'sd1,     1'b1, -16'sd1,     1'b0},
        '{ 16'sd21845, 1'b1,  16'sd21845, 1'b0},  // 0x5555
        '{-16'sd21846, 1'b1, -16'sd21846, 1'b0},  // 0xAAAA
        '{ 16'sd32767, 1'b1,  16'sd32767, 1'b1},  // history now full
        '{ 16'sd0,     1'b1,  16'sd32767, 1'b1},  // hold: newest returned
        '{ 16'sd0,     1'b1,  16'sd32767, 1'b1},  // hold twice in a row
        '{ 16'sd100,   1'b0,  16'sd0,     1'b0},
        '{-16'sd32768, 1'b0,  16'sd0,     1'b0},
        '{ 16'sd0,     1'b1, -16'sd32768, 1'b1},
        '{ 16'sd12345, 1'b0,  16'sd0,     1'b0},
        '{-16'sd16384, 1'b0,  16'sd0,     1'b0},
        '{ 16'sd0,     1'b1, -16'sd16384, 1'b1}
    };

    weighted_moving_average_hold_top dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_sample_in    (sample_in),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_estimate     (estimate),
        .o_history_full (history_full),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Model: advance history/fill for one accepted sample, return the word.
    // ------------------------------------------------------------------------
    function automatic t_estimate_word predict_estimate(input wmah_pkg::t_sample s);
        longint         acc;
        longint         q;
        int             i;
        t_estimate_word w;
        acc = 0;
        if (fill < TAPS) begin
            hist[fill] = s;
            fill++;
            w.estimate = s;
        end else if (s == 0) begin
            // not visible: history untouched, newest stored sample repeats
            w.estimate = hist[TAPS-1];
        end else begin
            for (i = 0; i < TAPS - 1; i++) begin
                hist[i] = hist[i+1];
            end
            hist[TAPS-1] = s;
            for (i = 0; i < TAPS; i++) begin
                acc += longint'(hist[i]) * longint'(wt[i]);
            end
            // round half up, then clamp to 16 bits
            q = (acc + 64'sd16384) >>> 15;
            if (q > 32767) begin
                w.estimate = 16'sd32767;
            end else if (q < -32768) begin
                w.estimate = -16'sd32768;
            end else begin
                w.estimate = wmah_pkg::t_sample'(q);
            end
        end
        w.history_full = (fill >= TAPS);
        return w;
    endfunction

    // mix of holds, corner values, small values and full-range noise
    function automatic wmah_pkg::t_sample pick_sample();
        wmah_pkg::t_sample corner [6];
        corner = '{16'sd32767, -16'sd32768, 16'sd16384, -16'sd16384, 16'sd1, -16'sd1};
        case ($urandom_range(0, 9))
            0, 1:    return '0;
            2:       return corner[$urandom_range(0, 5)];
            3:       return wmah_pkg::t_sample'($urandom_range(0, 255)) - 16'sd128;
            default: return wmah_pkg::t_sample'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Input side. valid stays up between back-to-back words; a random gap
    // drops it first. The word is held until the edge that takes it.
    // ------------------------------------------------------------------------
    task automatic send_sample(input wmah_pkg::t_sample s, input bit typed,
                               input t_estimate_word typed_word);
        t_estimate_word w;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        sample_in <= s;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        w = predict_estimate(s);
        estimates_due[due_wr % DUE_DEPTH] = typed ? typed_word : w;
        due_wr++;
    endtask

    // drop valid, let every owed word come out, then give the pipe time
    task automatic drain_block();
        in_valid <= 1'b0;
        while (due_wr != due_rd) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input wmah_pkg::t_cfg_idx idx, input wmah_pkg::t_sample v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        if (idx < REG_FIRST_UNUSED) begin
            wt[int'(idx - wmah_pkg::REG_WEIGHT_0)] = v;
        end
    endtask

    task automatic program_weights(input int phase);
        int                i;
        wmah_pkg::t_sample v;
        for (i = 0; i < N_WEIGHTS; i++) begin
            case (phase)
                1:       v = 16'sd32767;                         // max gain
                2:       v = -16'sd32768;                        // max negative
                3:       v = (i == TAPS - 1) ? 16'sd1 : 16'sd0;  // rounding probe
                5:       v = wmah_pkg::t_sample'($urandom_range(0, 8191)) - 16'sd4096;
                default: v = wmah_pkg::t_sample'($urandom);
            endcase
            write_reg(wmah_pkg::REG_WEIGHT_0 + wmah_pkg::t_cfg_idx'(i), v);
        end
        // out-of-map index, must leave all weights alone
        write_reg(phase[0] ? REG_FIRST_UNUSED : REG_LAST_UNUSED,
                  wmah_pkg::t_sample'($urandom));
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Output side stall: random short bursts, one long hold on request.
    // stall_left counts extra stalled cycles after the current one.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (hold_off_req) begin
            hold_off_req = 1'b0;
            out_stall    <= 1'b1;
            stall_left   <= LONG_HOLD;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 6);
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Result checker: every word taken is compared with the oldest one owed
    always @(posedge clk) begin
        t_estimate_word want;
        if (rst_n && out_valid && !out_stall) begin
            if (due_wr == due_rd) begin
                $display("%0t: unexpected word: estimate %0d history_full %0b",
                         $time, estimate, history_full);
                err_cnt++;
            end else begin
                want = estimates_due[due_rd % DUE_DEPTH];
                due_rd++;
                if (estimate !== want.estimate) begin
                    $display("%0t: estimate mismatch: expected %0d, actual %0d",
                             $time, want.estimate, estimate);
                    err_cnt++;
                end
                if (history_full !== want.history_full) begin
                    $display("%0t: history_full mismatch: expected %0b, actual %0b",
                             $time, want.history_full, history_full);
                    err_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int i;
        int phase;
        for (i = 0; i < N_WEIGHTS; i++) begin
            wt[i] = wmah_pkg::WEIGHT_RST;
        end
        for (i = 0; i < TAPS; i++) begin
            hist[i] = '0;
        end
        fill = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table under reset weights
        for (i = 0; i < 16; i++) begin
            send_sample(dir_tbl[i].smp, dir_tbl[i].typed,
                        t_estimate_word'{dir_tbl[i].est, dir_tbl[i].full});
        end

        for (phase = 0; phase < N_PHASES; phase++) begin
            if (phase != 0) begin
                drain_block();
                program_weights(phase);
            end
            // phase 1 and the final phase run with no idling on either side
            idle_on = (phase != 1) && (phase != N_PHASES - 1);
            // long output hold while words keep coming, fills the block
            if (phase == 4) begin
                hold_off_req = 1'b1;
            end
            for (i = 0; i < RAND_PER_PHASE; i++) begin
                send_sample(pick_sample(), 1'b0, '0);
            end
        end

        drain_block();
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
